// ----- src/qvr_pkg.sv -----
// Package for the quaternion vector rotation core.
// Holds fixed field widths, register indexes, reset values and shared types.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package qvr_pkg;

	localparam int Q_W       = 16;
	localparam int SQ_W      = 2 * Q_W;
	localparam int MAT_W     = SQ_W + 2;
	localparam int OUT_W     = 18;
	localparam int RND_SHIFT = 28;
	localparam int CFG_IDX_W = 8;

	localparam logic [CFG_IDX_W-1:0] REG_QUAT_SCALAR = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_QUAT_I      = 8'd1;
	localparam logic [CFG_IDX_W-1:0] REG_QUAT_J      = 8'd2;
	localparam logic [CFG_IDX_W-1:0] REG_QUAT_K      = 8'd3;

	localparam logic signed [Q_W-1:0] QUAT_SCALAR_RST = 16'sh4000;
	localparam logic signed [Q_W-1:0] QUAT_VEC_RST    = 16'sh0000;

	typedef logic signed [Q_W-1:0]   quat_comp_t;
	typedef logic signed [SQ_W-1:0]  sq_t;
	typedef logic signed [MAT_W-1:0] mat_t;

	typedef struct packed {
		logic en_s3;
		logic en_s4;
	} stage_en_t;

endpackage
`default_nettype wire

// ----- src/qvr_row.sv -----
// One row of the rotation: three products against the vector, then sum and round.
// Pipeline stages 3 and 4 of the core. Depends on qvr_pkg.
`timescale 1ns / 1ps
`default_nettype none
module qvr_row #(
	parameter int VECTOR_WIDTH = 16
) (
	input  wire logic                      clk,
	input  wire qvr_pkg::stage_en_t        ctl,
	input  wire qvr_pkg::mat_t             m0,
	input  wire qvr_pkg::mat_t             m1,
	input  wire qvr_pkg::mat_t             m2,
	input  wire logic signed [VECTOR_WIDTH-1:0] v0,
	input  wire logic signed [VECTOR_WIDTH-1:0] v1,
	input  wire logic signed [VECTOR_WIDTH-1:0] v2,
	output logic signed [VECTOR_WIDTH+qvr_pkg::MAT_W+2-qvr_pkg::RND_SHIFT-1:0] rnd_s4
);

	localparam int PROD_W = qvr_pkg::MAT_W + VECTOR_WIDTH;
	localparam int SUM_W  = PROD_W + 2;
	localparam int RND_W  = SUM_W - qvr_pkg::RND_SHIFT;
	localparam logic signed [SUM_W-1:0] HALF = SUM_W'(1) << (qvr_pkg::RND_SHIFT - 1);

	logic signed [PROD_W-1:0] p0_s3, p1_s3, p2_s3;
	logic signed [SUM_W-1:0]  sum;

	always_ff @(posedge clk) begin
		if (ctl.en_s3) begin
			p0_s3 <= m0 * v0;
			p1_s3 <= m1 * v1;
			p2_s3 <= m2 * v2;
		end
	end

	assign sum = SUM_W'(p0_s3) + SUM_W'(p1_s3) + SUM_W'(p2_s3) + HALF;

	always_ff @(posedge clk) begin
		if (ctl.en_s4) begin
			rnd_s4 <= RND_W'(sum >>> qvr_pkg::RND_SHIFT);
		end
	end

endmodule
`default_nettype wire

// ----- src/quaternion_vector_rotate_core.sv -----
// Quaternion vector rotation core: rotates a stream of vectors by q * v * conj(q).
// Top level; uses qvr_pkg and three qvr_row instances.
//
// Usage:
//   Input channel (in_valid / in_stall, vec_x/y/z) takes one vector per item.
//   Output channel (out_valid / out_stall, rot_x/y/z, saturated) returns one
//   rotated vector per item, in order.
//   Configuration channel (cfg_valid / cfg_ready, cfg_index, cfg_data) writes
//   the quaternion: 0 scalar, 1 i, 2 j, 3 k, each signed Q2.14. Other indexes
//   are dropped. cfg_ready is always high.
//   An accepted item passes through the five-stage pipeline (quaternion
//   squares, matrix terms, row products, row sum and round, saturation)
//   before out_valid rises; throughput is one item per cycle while the
//   receiver does not stall.
//   The quaternion is sampled when an item enters, so a write takes effect for
//   the next item accepted.
//   Reset clears all stage valid bits and loads the identity quaternion.
//   When the receiver stalls, the output holds; earlier stages keep filling
//   any empty slot, and in_stall rises only once every stage holds an item.
`timescale 1ns / 1ps
`default_nettype none
module quaternion_vector_rotate_core #(
	parameter int VECTOR_WIDTH = 16
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                in_valid,
	output logic                                     in_stall,
	input  wire logic signed [VECTOR_WIDTH-1:0]      vec_x,
	input  wire logic signed [VECTOR_WIDTH-1:0]      vec_y,
	input  wire logic signed [VECTOR_WIDTH-1:0]      vec_z,
	output logic                                     out_valid,
	input  wire logic                                out_stall,
	output logic signed [qvr_pkg::OUT_W-1:0]         rot_x,
	output logic signed [qvr_pkg::OUT_W-1:0]         rot_y,
	output logic signed [qvr_pkg::OUT_W-1:0]         rot_z,
	output logic                                     saturated,
	input  wire logic                                cfg_valid,
	output logic                                     cfg_ready,
	input  wire logic [qvr_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire logic [qvr_pkg::Q_W-1:0]             cfg_data
);

	localparam int RND_W = VECTOR_WIDTH + qvr_pkg::MAT_W + 2 - qvr_pkg::RND_SHIFT;
	localparam int EXT_W = (RND_W > qvr_pkg::OUT_W) ? RND_W : qvr_pkg::OUT_W;
	localparam logic signed [EXT_W-1:0] OUT_MAX = EXT_W'((2 ** (qvr_pkg::OUT_W - 1)) - 1);
	localparam logic signed [EXT_W-1:0] OUT_MIN = -(EXT_W'(2 ** (qvr_pkg::OUT_W - 1)));

	qvr_pkg::quat_comp_t qs_q, qi_q, qj_q, qk_q;

	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;
	logic ready_s1, ready_s2, ready_s3, ready_s4, ready_s5;

	qvr_pkg::sq_t ss_s1, xx_s1, yy_s1, zz_s1, xy_s1, sz_s1, xz_s1, sy_s1, yz_s1, sx_s1;
	logic signed [VECTOR_WIDTH-1:0] v_s1 [3];
	logic signed [VECTOR_WIDTH-1:0] v_s2 [3];
	qvr_pkg::mat_t mat_s2 [3][3];

	qvr_pkg::stage_en_t row_ctl;
	logic signed [RND_W-1:0] rnd_s4 [3];
	logic signed [EXT_W-1:0] ext [3];
	logic signed [qvr_pkg::OUT_W-1:0] clip [3];
	logic [2:0] sat_bit;

	// configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qs_q <= qvr_pkg::QUAT_SCALAR_RST;
			qi_q <= qvr_pkg::QUAT_VEC_RST;
			qj_q <= qvr_pkg::QUAT_VEC_RST;
			qk_q <= qvr_pkg::QUAT_VEC_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				qvr_pkg::REG_QUAT_SCALAR: qs_q <= cfg_data;
				qvr_pkg::REG_QUAT_I:      qi_q <= cfg_data;
				qvr_pkg::REG_QUAT_J:      qj_q <= cfg_data;
				qvr_pkg::REG_QUAT_K:      qk_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// stage readiness: a stage loads when empty or when its successor moves
	always_comb begin
		ready_s5 = !valid_s5 || !out_stall;
		ready_s4 = !valid_s4 || ready_s5;
		ready_s3 = !valid_s3 || ready_s4;
		ready_s2 = !valid_s2 || ready_s3;
		ready_s1 = !valid_s1 || ready_s2;
	end

	assign in_stall  = !ready_s1;
	assign out_valid = valid_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			if (ready_s1) valid_s1 <= in_valid;
			if (ready_s2) valid_s2 <= valid_s1;
			if (ready_s3) valid_s3 <= valid_s2;
			if (ready_s4) valid_s4 <= valid_s3;
			if (ready_s5) valid_s5 <= valid_s4;
		end
	end

	// stage 1: quaternion products, capture vector
	always_ff @(posedge clk) begin
		if (ready_s1) begin
			ss_s1  <= qs_q * qs_q;
			xx_s1  <= qi_q * qi_q;
			yy_s1  <= qj_q * qj_q;
			zz_s1  <= qk_q * qk_q;
			xy_s1  <= qi_q * qj_q;
			sz_s1  <= qs_q * qk_q;
			xz_s1  <= qi_q * qk_q;
			sy_s1  <= qs_q * qj_q;
			yz_s1  <= qj_q * qk_q;
			sx_s1  <= qs_q * qi_q;
			v_s1[0] <= vec_x;
			v_s1[1] <= vec_y;
			v_s1[2] <= vec_z;
		end
	end

	// stage 2: rotation matrix terms
	always_ff @(posedge clk) begin
		if (ready_s2) begin
			mat_s2[0][0] <= qvr_pkg::MAT_W'(ss_s1) + qvr_pkg::MAT_W'(xx_s1)
				- qvr_pkg::MAT_W'(yy_s1) - qvr_pkg::MAT_W'(zz_s1);
			mat_s2[0][1] <= (qvr_pkg::MAT_W'(xy_s1) - qvr_pkg::MAT_W'(sz_s1)) <<< 1;
			mat_s2[0][2] <= (qvr_pkg::MAT_W'(xz_s1) + qvr_pkg::MAT_W'(sy_s1)) <<< 1;
			mat_s2[1][0] <= (qvr_pkg::MAT_W'(xy_s1) + qvr_pkg::MAT_W'(sz_s1)) <<< 1;
			mat_s2[1][1] <= qvr_pkg::MAT_W'(ss_s1) - qvr_pkg::MAT_W'(xx_s1)
				+ qvr_pkg::MAT_W'(yy_s1) - qvr_pkg::MAT_W'(zz_s1);
			mat_s2[1][2] <= (qvr_pkg::MAT_W'(yz_s1) - qvr_pkg::MAT_W'(sx_s1)) <<< 1;
			mat_s2[2][0] <= (qvr_pkg::MAT_W'(xz_s1) - qvr_pkg::MAT_W'(sy_s1)) <<< 1;
			mat_s2[2][1] <= (qvr_pkg::MAT_W'(yz_s1) + qvr_pkg::MAT_W'(sx_s1)) <<< 1;
			mat_s2[2][2] <= qvr_pkg::MAT_W'(ss_s1) - qvr_pkg::MAT_W'(xx_s1)
				- qvr_pkg::MAT_W'(yy_s1) + qvr_pkg::MAT_W'(zz_s1);
			v_s2 <= v_s1;
		end
	end

	// stages 3 and 4: row products, sum and round
	assign row_ctl.en_s3 = ready_s3;
	assign row_ctl.en_s4 = ready_s4;

	for (genvar r = 0; r < 3; r++) begin : g_row
		qvr_row #(
			.VECTOR_WIDTH(VECTOR_WIDTH)
		) u_row (
			.clk    (clk),
			.ctl    (row_ctl),
			.m0     (mat_s2[r][0]),
			.m1     (mat_s2[r][1]),
			.m2     (mat_s2[r][2]),
			.v0     (v_s2[0]),
			.v1     (v_s2[1]),
			.v2     (v_s2[2]),
			.rnd_s4 (rnd_s4[r])
		);

		assign ext[r] = EXT_W'(rnd_s4[r]);

		always_comb begin
			sat_bit[r] = 1'b0;
			clip[r]    = qvr_pkg::OUT_W'(ext[r]);
			if (ext[r] > OUT_MAX) begin
				clip[r]    = qvr_pkg::OUT_W'(OUT_MAX);
				sat_bit[r] = 1'b1;
			end else if (ext[r] < OUT_MIN) begin
				clip[r]    = qvr_pkg::OUT_W'(OUT_MIN);
				sat_bit[r] = 1'b1;
			end
		end
	end

	// stage 5: saturate into the output register
	always_ff @(posedge clk) begin
		if (ready_s5) begin
			rot_x     <= clip[0];
			rot_y     <= clip[1];
			rot_z     <= clip[2];
			saturated <= |sat_bit;
		end
	end

endmodule
`default_nettype wire

// ----- src/qvr_checker.sv -----
// Port-level checks for the quaternion vector rotation core, with its bind.
// Depends on qvr_pkg and quaternion_vector_rotate_core.
`timescale 1ns / 1ps
`default_nettype none
module qvr_checker (
	input wire logic                        clk,
	input wire logic                        arst_n,
	input wire logic                        in_stall,
	input wire logic                        out_valid,
	input wire logic                        out_stall,
	input wire logic signed [qvr_pkg::OUT_W-1:0] rot_x,
	input wire logic signed [qvr_pkg::OUT_W-1:0] rot_y,
	input wire logic signed [qvr_pkg::OUT_W-1:0] rot_z,
	input wire logic                        saturated
);

	localparam logic signed [qvr_pkg::OUT_W-1:0] OUT_MAX = {1'b0, {(qvr_pkg::OUT_W-1){1'b1}}};
	localparam logic signed [qvr_pkg::OUT_W-1:0] OUT_MIN = {1'b1, {(qvr_pkg::OUT_W-1){1'b0}}};

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(rot_x) && $stable(rot_y)
			&& $stable(rot_z) && $stable(saturated))
		else $error("output item changed while stalled");

	a_out_drop: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(out_valid) |-> $past(!out_stall))
		else $error("output item dropped without handshake");

	a_in_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled while output side can move");

	a_sat_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && saturated |-> rot_x == OUT_MAX || rot_x == OUT_MIN
			|| rot_y == OUT_MAX || rot_y == OUT_MIN
			|| rot_z == OUT_MAX || rot_z == OUT_MIN)
		else $error("saturated flag without a clipped component");

endmodule

bind quaternion_vector_rotate_core qvr_checker u_qvr_checker (.*);
`default_nettype wire
